// File: design/dscm_pkg.sv
// Shared types, constants and register map for the drive enable and
// s-curve move unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dscm_pkg;

  // Configuration port geometry
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_STEP_DISTANCE    = 2'd0;
  localparam logic [1:0] REG_PROFILE_CYCLES   = 2'd1;
  localparam logic [1:0] REG_ARRIVE_TOLERANCE = 2'd2;
  localparam logic [1:0] REG_DWELL_CYCLES     = 2'd3;

  // Register reset values
  localparam logic [23:0] RST_STEP_DISTANCE    = 24'd100000;
  localparam logic [11:0] RST_PROFILE_CYCLES   = 12'd200;
  localparam logic [15:0] RST_ARRIVE_TOLERANCE = 16'd50;
  localparam logic [15:0] RST_DWELL_CYCLES     = 16'd1000;

  // Status word masks and patterns
  localparam logic [15:0] SW_MASK_FAULT  = 16'h004F;
  localparam logic [15:0] SW_MASK_STATE  = 16'h006F;
  localparam logic [15:0] SW_FAULT       = 16'h0008;
  localparam logic [15:0] SW_SW_ON_DIS   = 16'h0040;
  localparam logic [15:0] SW_READY       = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON = 16'h0023;
  localparam logic [15:0] SW_OP_ENABLED  = 16'h0027;

  // Control words and operating mode
  localparam logic [7:0] CW_FAULT_RESET = 8'h80;
  localparam logic [7:0] CW_SHUTDOWN    = 8'h06;
  localparam logic [7:0] CW_SWITCH_ON   = 8'h07;
  localparam logic [7:0] CW_ENABLE_OP   = 8'h0F;
  localparam logic [3:0] MODE_CSP       = 4'd8;

  // Arithmetic widths of the profile point
  localparam int MUL_W  = 24;         // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;  // registered product width
  localparam int NUM_W  = 60;         // delta * k^2 * (3N - 2k)
  localparam int DEN_W  = 36;         // N^3
  localparam int QUO_W  = 24;         // quotient never exceeds |delta|
  localparam int HALF_T = 18;         // split of the 36-bit k^2*(3N-2k) term

  typedef struct packed {
    logic [23:0] step_distance;
    logic [11:0] profile_cycles;
    logic [15:0] arrive_tolerance;
    logic [15:0] dwell_cycles;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_START,
    S_CHECK,
    S_MUL_KK,
    S_MUL_N2,
    S_MUL_T,
    S_MUL_D,
    S_MUL_LO,
    S_MUL_HI,
    S_ADD,
    S_DIV,
    S_APPLY,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// File: design/dscm_cfg.sv
// APB-style configuration registers of the move unit.
// Depends on dscm_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none
module dscm_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [dscm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [dscm_pkg::DATA_W-1:0] pwdata,
  output logic      [dscm_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output dscm_pkg::cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed register at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_distance    <= dscm_pkg::RST_STEP_DISTANCE;
      cfg.profile_cycles   <= dscm_pkg::RST_PROFILE_CYCLES;
      cfg.arrive_tolerance <= dscm_pkg::RST_ARRIVE_TOLERANCE;
      cfg.dwell_cycles     <= dscm_pkg::RST_DWELL_CYCLES;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        dscm_pkg::REG_STEP_DISTANCE:    cfg.step_distance    <= pwdata[23:0];
        dscm_pkg::REG_PROFILE_CYCLES:   cfg.profile_cycles   <= pwdata[11:0];
        dscm_pkg::REG_ARRIVE_TOLERANCE: cfg.arrive_tolerance <= pwdata[15:0];
        dscm_pkg::REG_DWELL_CYCLES:     cfg.dwell_cycles     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    unique case (paddr[3:2])
      dscm_pkg::REG_STEP_DISTANCE:    prdata = {8'd0, cfg.step_distance};
      dscm_pkg::REG_PROFILE_CYCLES:   prdata = {20'd0, cfg.profile_cycles};
      dscm_pkg::REG_ARRIVE_TOLERANCE: prdata = {16'd0, cfg.arrive_tolerance};
      dscm_pkg::REG_DWELL_CYCLES:     prdata = {16'd0, cfg.dwell_cycles};
      default:                        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/dscm_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on dscm_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none
module dscm_mul (
  input  wire logic                         clk,
  input  wire logic [dscm_pkg::MUL_W-1:0]   a,
  input  wire logic [dscm_pkg::MUL_W-1:0]   b,
  output logic      [dscm_pkg::PROD_W-1:0]  p
);

  // Register the product for the next sequencer step
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// File: design/dscm_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on dscm_pkg for operand widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none
module dscm_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [dscm_pkg::NUM_W-1:0]  num,
  input  wire logic [dscm_pkg::DEN_W-1:0]  den,
  output logic      [dscm_pkg::QUO_W-1:0]  quo,
  output dscm_pkg::div_stat_t              stat
);

  localparam int CNT_W = $clog2(dscm_pkg::QUO_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(dscm_pkg::QUO_W - 1);

  logic [dscm_pkg::DEN_W-1:0] rem;
  logic [dscm_pkg::QUO_W-1:0] low;
  logic [CNT_W-1:0]           cnt;
  logic [dscm_pkg::DEN_W:0]   trial;
  logic [dscm_pkg::DEN_W:0]   diff;
  logic                       ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem, low[dscm_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};
  assign quo   = low;

  // Control: busy while the quotient bits are formed, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the low word
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[dscm_pkg::NUM_W-1:dscm_pkg::QUO_W];
      low <= num[dscm_pkg::QUO_W-1:0];
    end else if (stat.busy) begin
      rem <= ge ? diff[dscm_pkg::DEN_W-1:0] : trial[dscm_pkg::DEN_W-1:0];
      low <= {low[dscm_pkg::QUO_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: design/drive_enable_and_s_curve_move_unit.sv
// Drive enable sequencer with a smoothstep back-and-forth move generator.
// One input transfer is one process-data cycle (frame_ok, status_word,
// actual_position); each yields one result transfer with control_word,
// op_mode, target_position, moving and dwelling.
// Configuration goes through the APB-style port (step_distance at 0x0,
// profile_cycles at 0x4, arrive_tolerance at 0x8, dwell_cycles at 0xC);
// pready is always high and reads return the register value.
// A bad frame or a plain enable step passes through S_DECODE and S_OUT;
// its result is loaded as in_ready returns, at the same edge. Arrival,
// timeout, dwell and idle cycles pass S_DECODE, S_START, S_CHECK and S_OUT.
// A profile point runs through the shared 24x24 multiplier six times and
// then a 24-step serial divider before S_APPLY and S_OUT; most of that
// time goes into the divider.
// in_ready is high only while the sequencer is idle; one item is in work
// at a time. A finished result sits in the output register while the next
// item is taken; if the receiver still stalls when the next result is done,
// the sequencer holds it until the output register frees.
// Reset (rst, synchronous) clears control word, mode, target and move state,
// sets the positive direction first, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module drive_enable_and_s_curve_move_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        frame_ok,
  input  wire logic [15:0]                 status_word,
  input  wire logic signed [31:0]          actual_position,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       control_word,
  output logic [3:0]                       op_mode,
  output logic signed [31:0]               target_position,
  output logic                             moving,
  output logic                             dwelling,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dscm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [dscm_pkg::DATA_W-1:0] pwdata,
  output logic      [dscm_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  dscm_pkg::cfg_t      cfg;
  dscm_pkg::state_t    state, state_next;
  dscm_pkg::div_stat_t div_stat;

  // Latched input item
  logic        frame_reg;
  logic [15:0] status_reg;
  logic [31:0] pos_reg;

  // Drive and move state
  logic [7:0]  control_reg;
  logic [3:0]  mode_reg;
  logic [31:0] target_reg;
  logic [31:0] move_start;
  logic [31:0] move_end;
  logic        move_active;
  logic        go_positive;
  logic [12:0] step_index;
  logic [15:0] dwell_left;

  // Profile point working registers
  logic [11:0] k_reg;
  logic [13:0] coef;
  logic [23:0] mag;
  logic        neg;
  logic [23:0] kk;
  logic [23:0] n2;
  logic [35:0] tval;
  logic [35:0] den;
  logic [41:0] plo;

  // Shared units
  logic [dscm_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [dscm_pkg::PROD_W-1:0] prod;
  logic [dscm_pkg::NUM_W-1:0]  div_num;
  logic [dscm_pkg::QUO_W-1:0]  quo;
  logic                        div_start;

  // Combinational helpers
  logic        accept_in;
  logic        out_free;
  logic [15:0] sw_f;
  logic [15:0] sw_s;
  logic [11:0] n_eff;
  logic [11:0] k_val;
  logic [13:0] coef_val;
  logic [32:0] pos33;
  logic [32:0] end_sum;
  logic [31:0] end_sat;
  logic [32:0] err;
  logic [32:0] aerr;
  logic        arrived;
  logic [32:0] delta;
  logic [32:0] mag_val;
  logic [31:0] q_ext;

  dscm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dscm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  dscm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .quo   (quo),
    .stat  (div_stat)
  );

  assign accept_in = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign sw_f      = status_reg & dscm_pkg::SW_MASK_FAULT;
  assign sw_s      = status_reg & dscm_pkg::SW_MASK_STATE;

  // Profile length and clamped step
  assign n_eff    = (cfg.profile_cycles == 12'd0) ? 12'd1 : cfg.profile_cycles;
  assign k_val    = (step_index < {1'b0, n_eff}) ? step_index[11:0] : n_eff;
  assign coef_val = {1'b0, n_eff, 1'b0} + {2'b00, n_eff} - {1'b0, k_val, 1'b0};

  // End position with saturation to the int32 range
  assign pos33   = {pos_reg[31], pos_reg};
  assign end_sum = go_positive ? pos33 + {9'd0, cfg.step_distance}
                               : pos33 - {9'd0, cfg.step_distance};
  assign end_sat = (end_sum[32] != end_sum[31])
                   ? (end_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                   : end_sum[31:0];

  // Arrival test on the exact difference
  assign err     = pos33 - {move_end[31], move_end};
  assign aerr    = err[32] ? (~err + 33'd1) : err;
  assign arrived = aerr <= {17'd0, cfg.arrive_tolerance};

  // Move length; it never exceeds step_distance
  assign delta   = {move_end[31], move_end} - {move_start[31], move_start};
  assign mag_val = delta[32] ? (~delta + 33'd1) : delta;

  // Numerator: high partial product shifted onto the low one
  assign div_num = {prod[41:0], {dscm_pkg::HALF_T{1'b0}}} + {18'd0, plo};
  assign q_ext   = {8'd0, quo};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dscm_pkg::S_IDLE:   if (in_valid) state_next = dscm_pkg::S_DECODE;
      dscm_pkg::S_DECODE: begin
        if (frame_reg && sw_f != dscm_pkg::SW_FAULT && sw_f != dscm_pkg::SW_SW_ON_DIS
            && sw_s != dscm_pkg::SW_READY && sw_s != dscm_pkg::SW_SWITCHED_ON
            && sw_s == dscm_pkg::SW_OP_ENABLED) begin
          state_next = dscm_pkg::S_START;
        end else begin
          state_next = dscm_pkg::S_OUT;
        end
      end
      dscm_pkg::S_START:  state_next = dscm_pkg::S_CHECK;
      dscm_pkg::S_CHECK: begin
        if (move_active && !arrived && step_index <= {1'b0, n_eff}) begin
          state_next = dscm_pkg::S_MUL_KK;
        end else begin
          state_next = dscm_pkg::S_OUT;
        end
      end
      dscm_pkg::S_MUL_KK: state_next = dscm_pkg::S_MUL_N2;
      dscm_pkg::S_MUL_N2: state_next = dscm_pkg::S_MUL_T;
      dscm_pkg::S_MUL_T:  state_next = dscm_pkg::S_MUL_D;
      dscm_pkg::S_MUL_D:  state_next = dscm_pkg::S_MUL_LO;
      dscm_pkg::S_MUL_LO: state_next = dscm_pkg::S_MUL_HI;
      dscm_pkg::S_MUL_HI: state_next = dscm_pkg::S_ADD;
      dscm_pkg::S_ADD:    state_next = dscm_pkg::S_DIV;
      dscm_pkg::S_DIV:    if (div_stat.done) state_next = dscm_pkg::S_APPLY;
      dscm_pkg::S_APPLY:  state_next = dscm_pkg::S_OUT;
      dscm_pkg::S_OUT:    if (out_free) state_next = dscm_pkg::S_IDLE;
      default:            state_next = dscm_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands, divider start
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      dscm_pkg::S_IDLE:   in_ready = 1'b1;
      dscm_pkg::S_MUL_KK: begin
        mul_a = {12'd0, k_reg};
        mul_b = {12'd0, k_reg};
      end
      dscm_pkg::S_MUL_N2: begin
        mul_a = {12'd0, n_eff};
        mul_b = {12'd0, n_eff};
      end
      dscm_pkg::S_MUL_T: begin
        mul_a = kk;
        mul_b = {10'd0, coef};
      end
      dscm_pkg::S_MUL_D: begin
        mul_a = n2;
        mul_b = {12'd0, n_eff};
      end
      dscm_pkg::S_MUL_LO: begin
        mul_a = mag;
        mul_b = {6'd0, tval[dscm_pkg::HALF_T-1:0]};
      end
      dscm_pkg::S_MUL_HI: begin
        mul_a = mag;
        mul_b = {6'd0, tval[35:dscm_pkg::HALF_T]};
      end
      dscm_pkg::S_ADD:    div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dscm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (accept_in) begin
      frame_reg  <= frame_ok;
      status_reg <= status_word;
      pos_reg    <= actual_position;
    end
  end

  // Drive and move state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg <= '0;
      mode_reg    <= '0;
      target_reg  <= '0;
      move_start  <= '0;
      move_end    <= '0;
      move_active <= 1'b0;
      go_positive <= 1'b1;
      step_index  <= '0;
      dwell_left  <= '0;
    end else begin
      unique case (state)
        dscm_pkg::S_DECODE: begin
          if (frame_reg) begin
            mode_reg <= dscm_pkg::MODE_CSP;
            if (sw_f == dscm_pkg::SW_FAULT) begin
              control_reg <= dscm_pkg::CW_FAULT_RESET;
            end else if (sw_f == dscm_pkg::SW_SW_ON_DIS) begin
              control_reg <= dscm_pkg::CW_SHUTDOWN;
            end else if (sw_s == dscm_pkg::SW_READY) begin
              control_reg <= dscm_pkg::CW_SWITCH_ON;
            end else if (sw_s == dscm_pkg::SW_SWITCHED_ON) begin
              control_reg <= dscm_pkg::CW_ENABLE_OP;
            end
          end
        end
        dscm_pkg::S_START: begin
          // Begin a new move when neither moving nor dwelling
          if (!move_active && dwell_left == 16'd0) begin
            move_start  <= pos_reg;
            move_end    <= end_sat;
            step_index  <= '0;
            move_active <= 1'b1;
          end
        end
        dscm_pkg::S_CHECK: begin
          if (move_active) begin
            // Finish on arrival or timeout; profiling goes to the multiplier
            if (arrived || step_index > {1'b0, n_eff}) begin
              target_reg  <= move_end;
              move_active <= 1'b0;
              dwell_left  <= cfg.dwell_cycles;
              go_positive <= !go_positive;
            end
          end else begin
            target_reg <= move_end;
            if (dwell_left != 16'd0) begin
              dwell_left <= dwell_left - 16'd1;
            end
          end
        end
        dscm_pkg::S_APPLY: begin
          // Point lies between start and end, so no saturation is needed
          target_reg <= neg ? move_start - q_ext : move_start + q_ext;
          step_index <= step_index + 13'd1;
        end
        default: ;
      endcase
    end
  end

  // Profile point operands and partial results
  always_ff @(posedge clk) begin
    unique case (state)
      dscm_pkg::S_CHECK: begin
        k_reg <= k_val;
        coef  <= coef_val;
        mag   <= mag_val[23:0];
        neg   <= delta[32];
      end
      dscm_pkg::S_MUL_N2: kk   <= prod[23:0];
      dscm_pkg::S_MUL_T:  n2   <= prod[23:0];
      dscm_pkg::S_MUL_D:  tval <= prod[35:0];
      dscm_pkg::S_MUL_LO: den  <= prod[35:0];
      dscm_pkg::S_MUL_HI: plo  <= prod[41:0];
      default: ;
    endcase
  end

  // Output register: load the finished result, drop it on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == dscm_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dscm_pkg::S_OUT && out_free) begin
      control_word    <= control_reg;
      op_mode         <= mode_reg;
      target_position <= target_reg;
      moving          <= move_active;
      dwelling        <= dwell_left != 16'd0;
    end
  end

`ifndef SYNTHESIS
  a_no_move_while_dwell: assert property (@(posedge clk) disable iff (rst)
    !(move_active && dwell_left != 16'd0))
    else $error("move active while dwell counter nonzero");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == dscm_pkg::S_DIV)
    else $error("divider done outside the divide step");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == dscm_pkg::S_OUT && out_free) |=> out_valid)
    else $error("finished result not presented");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept_in |=> state == dscm_pkg::S_DECODE)
    else $error("accepted item did not start decode");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step_index[12] |-> step_index[11:0] == 12'd0)
    else $error("step index past profile bound");
`endif

endmodule
`default_nettype wire

// File: test/tb_drive_enable_and_s_curve_move_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for drive_enable_and_s_curve_move_unit: sends process-data
// cycles, predicts every result with its own model of the enable sequence and the
// smoothstep mover, and checks each result transfer. Depends on dscm_pkg and the unit.
module tb_drive_enable_and_s_curve_move_unit;

  localparam int     WATCHDOG_LIMIT  = 2000;
  localparam int     HOLD_OFF_CYCLES = 300;
  localparam int     SETTLE_CYCLES   = 60;
  localparam longint POS_MAX         = 64'sd2147483647;
  localparam longint POS_MIN         = -64'sd2147483648;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [7:0]         control;
    logic [3:0]         mode;
    logic signed [31:0] target;
    logic               moving;
    logic               dwelling;
  } drive_outputs_t;

  // DUT connections
  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready;
  logic frame_ok;
  logic [15:0] status_word;
  logic signed [31:0] actual_position;
  logic out_valid, out_ready;
  logic [7:0] control_word;
  logic [3:0] op_mode;
  logic signed [31:0] target_position;
  logic moving, dwelling;
  logic psel, penable, pwrite, pready;
  logic [dscm_pkg::ADDR_W-1:0] paddr;
  logic [dscm_pkg::DATA_W-1:0] pwdata, prdata;

  // Predicted drive state and configuration
  logic [23:0] cfg_distance;
  logic [11:0] cfg_profile;
  logic [15:0] cfg_tolerance;
  logic [15:0] cfg_dwell;
  logic [7:0]  pred_control;
  logic [3:0]  pred_mode;
  logic signed [31:0] pred_target;
  logic signed [31:0] pred_move_from;
  logic signed [31:0] pred_move_to;
  logic        pred_in_motion;
  logic        pred_heading_up;
  logic [12:0] pred_step;
  logic [15:0] pred_hold_left;

  drive_outputs_t pending_drive_outputs[$];
  int  mismatch_count = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  bit  no_gaps = 1'b0;
  logic hold_results = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  drive_enable_and_s_curve_move_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .frame_ok(frame_ok), .status_word(status_word), .actual_position(actual_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .control_word(control_word), .op_mode(op_mode), .target_position(target_position),
    .moving(moving), .dwelling(dwelling),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] clamp32(input longint v);
    logic signed [31:0] r;
    if (v > POS_MAX) r = INT_MAX;
    else if (v < POS_MIN) r = INT_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Smoothstep point: start + delta*k*k*(3N-2k)/N^3, truncated toward zero
  function automatic logic signed [31:0] smoothstep_target();
    longint unsigned n, k, mag, num, q;
    longint delta;
    n = (cfg_profile == 12'd0) ? 1 : cfg_profile;
    k = (pred_step < n) ? pred_step : n;
    delta = longint'(pred_move_to) - longint'(pred_move_from);
    mag = (delta < 0) ? -delta : delta;
    num = mag * k * k * (3 * n - 2 * k);
    q = num / (n * n * n);
    if (delta < 0) return clamp32(longint'(pred_move_from) - longint'(q));
    return clamp32(longint'(pred_move_from) + longint'(q));
  endfunction

  task automatic close_move();
    pred_target = pred_move_to;
    pred_in_motion = 1'b0;
    pred_hold_left = cfg_dwell;
    pred_heading_up = !pred_heading_up;
  endtask

  task automatic step_mover(input logic signed [31:0] pos);
    longint span, err;
    longint unsigned aerr;
    logic [12:0] n;
    span = cfg_distance;
    // latch a new move when nothing is running or holding
    if (!pred_in_motion && pred_hold_left == 16'd0) begin
      pred_move_from = pos;
      pred_move_to = clamp32(pred_heading_up ? longint'(pos) + span : longint'(pos) - span);
      pred_step = '0;
      pred_in_motion = 1'b1;
    end
    if (pred_in_motion) begin
      err = longint'(pos) - longint'(pred_move_to);
      aerr = (err < 0) ? -err : err;
      n = (cfg_profile == 12'd0) ? 13'd1 : {1'b0, cfg_profile};
      if (aerr <= cfg_tolerance) begin
        close_move();
      end else if (pred_step <= n) begin
        pred_target = smoothstep_target();
        pred_step = pred_step + 13'd1;
      end else begin
        close_move();
      end
    end else if (pred_hold_left != 16'd0) begin
      pred_target = pred_move_to;
      pred_hold_left = pred_hold_left - 16'd1;
    end else begin
      pred_target = pred_move_to;
    end
  endtask

  task automatic advance_drive_model(input logic ok, input logic [15:0] sw,
                                     input logic signed [31:0] pos);
    drive_outputs_t r;
    // a bad frame leaves everything as it was
    if (ok) begin
      pred_mode = dscm_pkg::MODE_CSP;
      if ((sw & dscm_pkg::SW_MASK_FAULT) == dscm_pkg::SW_FAULT)
        pred_control = dscm_pkg::CW_FAULT_RESET;
      else if ((sw & dscm_pkg::SW_MASK_FAULT) == dscm_pkg::SW_SW_ON_DIS)
        pred_control = dscm_pkg::CW_SHUTDOWN;
      else if ((sw & dscm_pkg::SW_MASK_STATE) == dscm_pkg::SW_READY)
        pred_control = dscm_pkg::CW_SWITCH_ON;
      else if ((sw & dscm_pkg::SW_MASK_STATE) == dscm_pkg::SW_SWITCHED_ON)
        pred_control = dscm_pkg::CW_ENABLE_OP;
      else if ((sw & dscm_pkg::SW_MASK_STATE) == dscm_pkg::SW_OP_ENABLED)
        step_mover(pos);
    end
    r.control = pred_control;
    r.mode = pred_mode;
    r.target = pred_target;
    r.moving = pred_in_motion;
    r.dwelling = (pred_hold_left != 16'd0);
    pending_drive_outputs.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Random don't-care bits around a status pattern
  function automatic logic [15:0] dress_status(input logic [15:0] pattern,
                                               input logic [15:0] mask);
    logic [15:0] noise;
    noise = $urandom_range(0, 16'hFFFF);
    return (noise & ~mask) | pattern;
  endfunction

  function automatic logic signed [31:0] jitter(input logic signed [31:0] center,
                                                input int unsigned spread);
    longint off;
    off = longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    return clamp32(longint'(center) + off);
  endfunction

  // Pick a measured position that drives the mover somewhere useful
  function automatic logic signed [31:0] next_position();
    int unsigned pick, tol;
    longint off;
    pick = $urandom_range(0, 99);
    tol = cfg_tolerance;
    if (!pred_in_motion && pred_hold_left == 16'd0) begin
      if (pick < 80) return jitter(0, 1 << 28);
      if (pick < 88) return jitter(INT_MAX, 1 << 24);
      if (pick < 96) return jitter(INT_MIN, 1 << 24);
      return $urandom;
    end
    if (pred_in_motion) begin
      if (pick < 55) return jitter(pred_target, 8);
      if (pick < 75) return jitter(pred_move_to, tol);
      if (pick < 87) begin
        off = longint'(tol) + 1;
        if ($urandom_range(0, 1)) off = -off;
        return clamp32(longint'(pred_move_to) + off);
      end
      return $urandom;
    end
    if (pick < 70) return jitter(pred_move_to, tol + 20);
    return $urandom;
  endfunction

  task automatic send_pd_cycle(input logic ok, input logic [15:0] sw,
                               input logic signed [31:0] pos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    frame_ok <= ok;
    status_word <= sw;
    actual_position <= pos;
    do @(posedge clk); while (!in_ready);
    advance_drive_model(ok, sw, pos);
  endtask

  // Mostly enabled cycles with mover-aware positions, plus enable steps and noise
  task automatic send_random_cycle();
    int unsigned pick;
    logic ok;
    logic [15:0] sw;
    logic signed [31:0] pos;
    pick = $urandom_range(0, 99);
    ok = 1'b1;
    pos = next_position();
    sw = dress_status(dscm_pkg::SW_OP_ENABLED, dscm_pkg::SW_MASK_STATE);
    if (pick < 6) begin
      ok = 1'b0;
      if ($urandom_range(0, 1)) sw = $urandom_range(0, 16'hFFFF);
    end else if (pick < 16) begin
      sw = $urandom_range(0, 16'hFFFF);
      pos = $urandom;
    end else if (pick < 28) begin
      case ($urandom_range(0, 3))
        0: sw = dress_status(dscm_pkg::SW_FAULT, dscm_pkg::SW_MASK_FAULT);
        1: sw = dress_status(dscm_pkg::SW_SW_ON_DIS, dscm_pkg::SW_MASK_FAULT);
        2: sw = dress_status(dscm_pkg::SW_READY, dscm_pkg::SW_MASK_STATE);
        default: sw = dress_status(dscm_pkg::SW_SWITCHED_ON, dscm_pkg::SW_MASK_STATE);
      endcase
    end
    send_pd_cycle(ok, sw, pos);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    // let the bus go idle between writes
    @(posedge clk);
    case (idx)
      dscm_pkg::REG_STEP_DISTANCE:    cfg_distance = value[23:0];
      dscm_pkg::REG_PROFILE_CYCLES:   cfg_profile = value[11:0];
      dscm_pkg::REG_ARRIVE_TOLERANCE: cfg_tolerance = value[15:0];
      dscm_pkg::REG_DWELL_CYCLES:     cfg_dwell = value[15:0];
      default: ;
    endcase
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_drive_outputs.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < 100)
      $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_enable_sequence();
    send_pd_cycle(1'b0, dscm_pkg::SW_OP_ENABLED, 0);
    send_pd_cycle(1'b1, dscm_pkg::SW_FAULT, 0);
    send_pd_cycle(1'b1, dscm_pkg::SW_SW_ON_DIS, 0);
    send_pd_cycle(1'b1, dscm_pkg::SW_READY, 0);
    send_pd_cycle(1'b1, dscm_pkg::SW_SWITCHED_ON, 0);
    send_pd_cycle(1'b1, 16'hFFFF, INT_MIN);
    send_pd_cycle(1'b1, 16'h0000, INT_MAX);
    // first move at the reset settings; the later send also sets the don't-care bits
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, 1000);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED | ~dscm_pkg::SW_MASK_STATE, pred_target);
    wait_for_idle();
    write_register(dscm_pkg::REG_DWELL_CYCLES, 1);
    // arrive right at the tolerance edge, then dwell one cycle
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, pred_move_to - 32'sd50);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, 0);
  endtask

  task automatic test_special_cases();
    wait_for_idle();
    write_register(dscm_pkg::REG_DWELL_CYCLES, 0);
    write_register(dscm_pkg::REG_PROFILE_CYCLES, 0);
    write_register(dscm_pkg::REG_ARRIVE_TOLERANCE, 0);
    // negative end saturates at the low limit and arrives at once
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, INT_MIN);
    // positive end saturates; a full-range error must not wrap; then time out
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, INT_MAX - 32'sd10);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, INT_MIN);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, 0);
    wait_for_idle();
    write_register(dscm_pkg::REG_PROFILE_CYCLES, 8);
    write_register(dscm_pkg::REG_ARRIVE_TOLERANCE, 50);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, 0);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, pred_target);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, pred_target);
    // shrink the profile mid-move so the step lands on its last point
    wait_for_idle();
    write_register(dscm_pkg::REG_PROFILE_CYCLES, 3);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, 0);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, 0);
    wait_for_idle();
    write_register(dscm_pkg::REG_STEP_DISTANCE, 0);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, 5);
    wait_for_idle();
    write_register(dscm_pkg::REG_STEP_DISTANCE, 32'h00FF_FFFF);
    write_register(dscm_pkg::REG_ARRIVE_TOLERANCE, 32'h0000_FFFF);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, 12345);
    send_pd_cycle(1'b1, dscm_pkg::SW_OP_ENABLED, pred_move_to - 32'sd65535);
  endtask

  task automatic test_random_moves(input int phases, input int per_phase);
    logic [31:0] span, prof, tol, dwell;
    for (int p = 0; p < phases; p++) begin
      wait_for_idle();
      case ($urandom_range(0, 9))
        0: span = 0;
        1: span = 32'h00FF_FFFF;
        default: span = $urandom_range(1, 6000);
      endcase
      case ($urandom_range(0, 9))
        0: prof = 0;
        1: prof = 1;
        2: prof = 4095;
        default: prof = $urandom_range(2, 24);
      endcase
      case ($urandom_range(0, 9))
        0: tol = 0;
        1: tol = 65535;
        default: tol = $urandom_range(1, 200);
      endcase
      dwell = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 6);
      write_register(dscm_pkg::REG_STEP_DISTANCE, span);
      write_register(dscm_pkg::REG_PROFILE_CYCLES, prof);
      write_register(dscm_pkg::REG_ARRIVE_TOLERANCE, tol);
      write_register(dscm_pkg::REG_DWELL_CYCLES, dwell);
      // every third phase runs back to back on both sides
      no_gaps = (p % 3 == 2);
      repeat (per_phase) send_random_cycle();
      no_gaps = 1'b0;
    end
  endtask

  // Largest profile and distance: widest products through the divider
  task automatic test_long_profile();
    wait_for_idle();
    write_register(dscm_pkg::REG_STEP_DISTANCE, 32'h00FF_FFFF);
    write_register(dscm_pkg::REG_PROFILE_CYCLES, 4095);
    write_register(dscm_pkg::REG_ARRIVE_TOLERANCE, $urandom_range(0, 1000));
    write_register(dscm_pkg::REG_DWELL_CYCLES, $urandom_range(0, 3));
    repeat (150) send_random_cycle();
  endtask

  // Hold the result side off while the sender keeps offering cycles
  task automatic test_backpressure();
    wait_for_idle();
    no_gaps = 1'b1;
    fork
      begin
        hold_results <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
      end
      repeat (40) send_random_cycle();
    join
    no_gaps = 1'b0;
  endtask

  task automatic test_long_dwell();
    wait_for_idle();
    write_register(dscm_pkg::REG_STEP_DISTANCE, 1000);
    write_register(dscm_pkg::REG_PROFILE_CYCLES, 4);
    write_register(dscm_pkg::REG_ARRIVE_TOLERANCE, 10);
    write_register(dscm_pkg::REG_DWELL_CYCLES, 32'h0000_FFFF);
    repeat (40) send_random_cycle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus the long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (stall > 0 || hold_results) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_results) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    drive_outputs_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_drive_outputs.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_drive_outputs.pop_front();
        if (control_word !== want.control)
          report_mismatch("control_word", control_word, want.control);
        if (op_mode !== want.mode)
          report_mismatch("op_mode", op_mode, want.mode);
        if (target_position !== want.target)
          report_mismatch("target_position", longint'(target_position), longint'(want.target));
        if (moving !== want.moving)
          report_mismatch("moving", moving, want.moving);
        if (dwelling !== want.dwelling)
          report_mismatch("dwelling", dwelling, want.dwelling);
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    frame_ok <= 1'b0;
    status_word <= '0;
    actual_position <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    // predicted state after reset
    cfg_distance = dscm_pkg::RST_STEP_DISTANCE;
    cfg_profile = dscm_pkg::RST_PROFILE_CYCLES;
    cfg_tolerance = dscm_pkg::RST_ARRIVE_TOLERANCE;
    cfg_dwell = dscm_pkg::RST_DWELL_CYCLES;
    pred_control = '0;
    pred_mode = '0;
    pred_target = '0;
    pred_move_from = '0;
    pred_move_to = '0;
    pred_in_motion = 1'b0;
    pred_heading_up = 1'b1;
    pred_step = '0;
    pred_hold_left = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_enable_sequence();
    test_special_cases();
    test_random_moves(5, 240);
    test_long_profile();
    test_backpressure();
    test_long_dwell();

    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
